### hdl/timeout_label_barrier_bias_macros.svh
// Assertion helpers for the timeout label barrier bias block.
`ifndef TIMEOUT_LABEL_BARRIER_BIAS_MACROS_SVH
`define TIMEOUT_LABEL_BARRIER_BIAS_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TLBB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TLBB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tlbb_pkg.sv
package tlbb_pkg;

    localparam int MAX_HORIZON  = 32;
    localparam int PRICE_BITS   = 24;
    localparam int DEPTH        = MAX_HORIZON + 1;
    localparam int CNT_BITS     = $clog2(DEPTH + 1);
    localparam int SEEN_BITS    = 6;
    localparam int TICK_BITS    = 12;
    localparam int HOR_BITS     = 6;
    localparam int CFG_IDX_BITS = 2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HORIZON = 2'd2;

    // label codes
    localparam logic signed [1:0] LABEL_UP      = 2'sd1;
    localparam logic signed [1:0] LABEL_DOWN    = -2'sd1;
    localparam logic signed [1:0] LABEL_TIMEOUT = 2'sd0;

    typedef logic [PRICE_BITS-1:0] price_t;

    typedef struct packed {
        logic signed [1:0] label_in;
        price_t            close_ticks;
        price_t            high_ticks;
        price_t            low_ticks;
        logic              last_bar;
    } bar_t;

    typedef struct packed {
        logic signed [1:0] label_out;
        logic              last_result;
    } result_t;

    // one pending bar
    typedef struct packed {
        logic signed [1:0]    label;
        price_t               close;
        price_t               peak_high;
        price_t               min_low;
        logic [SEEN_BITS-1:0] seen;
    } entry_t;

    typedef struct packed {
        logic update;   // fold the new bar into the window
        logic load;     // take the new bar as a fresh entry
        logic shift;    // take the neighbor's entry (head pop)
    } cell_ctrl_t;

endpackage

### hdl/timeout_label_barrier_bias.sv
// Timing: a bar is taken only while idle and folded into the cells; each
// result it completes goes to the one-word output register, one result per
// cycle while that register is free; no new bar is taken until they drain.
// A bar releases 0..33 results, and the queue shifts one cell per result.
// Reset: rst_n async low; empties the queue, registers back to 8 / 8 / 16.
module timeout_label_barrier_bias (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // bar channel
    input  logic                                 bar_valid,
    output logic                                 bar_ready,
    input  tlbb_pkg::bar_t                       bar_data,
    // result channel
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output tlbb_pkg::result_t                    res_data,
    // register write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [tlbb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [tlbb_pkg::TICK_BITS-1:0]       cfg_data
);

    `include "timeout_label_barrier_bias_macros.svh"

    localparam int CW = tlbb_pkg::CNT_BITS;
    localparam int DW = tlbb_pkg::PRICE_BITS + 3;   // signed distance width

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // ------------------------------------------------------------------
    // Configuration registers. Writes must land only while idle (user's rule, not enforced); always ready.
    // ------------------------------------------------------------------
    logic [tlbb_pkg::TICK_BITS-1:0] upper_reg;
    logic [tlbb_pkg::TICK_BITS-1:0] lower_reg;
    logic [tlbb_pkg::HOR_BITS-1:0]  horizon_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg   <= tlbb_pkg::TICK_BITS'(8);
            lower_reg   <= tlbb_pkg::TICK_BITS'(8);
            horizon_reg <= tlbb_pkg::HOR_BITS'(16);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tlbb_pkg::CFG_UPPER:   upper_reg   <= cfg_data;
                tlbb_pkg::CFG_LOWER:   lower_reg   <= cfg_data;
                tlbb_pkg::CFG_HORIZON: horizon_reg <= cfg_data[tlbb_pkg::HOR_BITS-1:0];
                default: ;   // unused index, write dropped
            endcase
        end
    end

    // Effective horizon: zero acts as one, clipped at the queue limit.
    logic [tlbb_pkg::HOR_BITS-1:0] h_eff;

    always_comb
    begin
        if (horizon_reg == '0)
        begin
            h_eff = tlbb_pkg::HOR_BITS'(1);
        end
        else if (horizon_reg > tlbb_pkg::HOR_BITS'(tlbb_pkg::MAX_HORIZON))
        begin
            h_eff = tlbb_pkg::HOR_BITS'(tlbb_pkg::MAX_HORIZON);
        end
        else
        begin
            h_eff = horizon_reg;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    state_t            state_reg;
    logic [CW-1:0]     count_reg;     // pending bars, cell 0 is the oldest
    logic              flush_reg;     // last bar seen, drain everything
    logic              res_valid_reg;
    tlbb_pkg::result_t res_data_reg;

    tlbb_pkg::entry_t entries [tlbb_pkg::DEPTH];
    tlbb_pkg::entry_t head;

    logic bar_fire;
    logic head_due;
    logic out_free;
    logic pop;
    logic last_pop;

    assign head      = entries[0];
    assign bar_ready = (state_reg == ST_IDLE);
    assign bar_fire  = bar_valid && bar_ready;
    // head leaves when its window is full, or on the flush after the last bar
    assign head_due  = (count_reg != '0) &&
                       ((head.seen >= h_eff) || flush_reg);
    assign out_free  = !res_valid_reg || res_ready;
    assign pop       = (state_reg == ST_EMIT) && head_due && out_free;
    // final word of the day: the flush pops the only remaining bar
    assign last_pop  = pop && flush_reg && (count_reg == CW'(1));

    // ------------------------------------------------------------------
    // Chain of cells. Every pending cell folds the new bar in the same
    // cycle; the bar itself lands in the first free cell. A pop moves
    // every cell one place toward the head.
    // ------------------------------------------------------------------
    for (genvar i = 0; i < tlbb_pkg::DEPTH; i++)
    begin : g_cell
        tlbb_pkg::cell_ctrl_t ctrl;
        tlbb_pkg::entry_t     nbr;

        assign ctrl = '{update: bar_fire && (CW'(i) < count_reg),
                        load:   bar_fire && (CW'(i) == count_reg),
                        shift:  pop};

        if (i == tlbb_pkg::DEPTH - 1)
        begin : g_tail
            assign nbr = entries[i];   // tail has no neighbor; stale after pop
        end
        else
        begin : g_mid
            assign nbr = entries[i + 1];
        end

        tlbb_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .bar        (bar_data),
            .next_entry (nbr),
            .entry      (entries[i])
        );
    end

    // ------------------------------------------------------------------
    // Tie-break of the head bar.
    //   up = C + upper - H,  lo = L - (C - lower)
    // Smaller distance wins; tie, or no later bar, stays timeout.
    // ------------------------------------------------------------------
    logic signed [DW-1:0] up_dist;
    logic signed [DW-1:0] lo_dist;
    logic signed [1:0]    head_label;

    always_comb
    begin
        up_dist = $signed({3'b000, head.close})
                + $signed({{(DW - tlbb_pkg::TICK_BITS){1'b0}}, upper_reg})
                - $signed({3'b000, head.peak_high});
        lo_dist = $signed({3'b000, head.min_low})
                - $signed({3'b000, head.close})
                + $signed({{(DW - tlbb_pkg::TICK_BITS){1'b0}}, lower_reg});
        if (head.label != tlbb_pkg::LABEL_TIMEOUT)
        begin
            head_label = head.label;   // includes the unused code, passed as is
        end
        else if (head.seen == '0)
        begin
            head_label = tlbb_pkg::LABEL_TIMEOUT;
        end
        else if (up_dist < lo_dist)
        begin
            head_label = tlbb_pkg::LABEL_UP;
        end
        else if (lo_dist < up_dist)
        begin
            head_label = tlbb_pkg::LABEL_DOWN;
        end
        else
        begin
            head_label = tlbb_pkg::LABEL_TIMEOUT;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: take a bar, then drain due heads into the result register.
    // A pop refills the result register even while its word is taken.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            flush_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            if (pop)
            begin
                res_valid_reg            <= 1'b1;
                res_data_reg.label_out   <= head_label;
                res_data_reg.last_result <= last_pop;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (bar_fire)
                    begin
                        if (count_reg < CW'(tlbb_pkg::DEPTH))
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        flush_reg <= bar_data.last_bar;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (pop)
                    begin
                        count_reg <= count_reg - CW'(1);
                    end
                    else if (!head_due)
                    begin
                        flush_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `TLBB_ASSERT_IMP(a_room_on_take, bar_fire, count_reg < CW'(tlbb_pkg::DEPTH), "queue full")
    `TLBB_ASSERT_NXT(a_take_grows, bar_fire, count_reg == $past(count_reg) + CW'(1), "no count step")
    `TLBB_ASSERT_NXT(a_last_marks_end, last_pop, res_valid && res_data.last_result, "last unmarked")

endmodule

### hdl/tlbb_cell.sv
module tlbb_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlbb_pkg::cell_ctrl_t ctrl,
    input  tlbb_pkg::bar_t       bar,
    input  tlbb_pkg::entry_t     next_entry,
    output tlbb_pkg::entry_t     entry
);

    tlbb_pkg::entry_t entry_reg;
    tlbb_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.load)
        begin
            entry_next.label     = bar.label_in;
            entry_next.close     = bar.close_ticks;
            entry_next.peak_high = '0;
            entry_next.min_low   = '0;
            entry_next.seen      = '0;
        end
        else if (ctrl.update)
        begin
            if (entry_reg.seen == '0)
            begin
                entry_next.peak_high = bar.high_ticks;
                entry_next.min_low   = bar.low_ticks;
            end
            else
            begin
                if (bar.high_ticks > entry_reg.peak_high)
                begin
                    entry_next.peak_high = bar.high_ticks;
                end
                if (bar.low_ticks < entry_reg.min_low)
                begin
                    entry_next.min_low = bar.low_ticks;
                end
            end
            if (entry_reg.seen != '1)
            begin
                entry_next.seen = entry_reg.seen + tlbb_pkg::SEEN_BITS'(1);
            end
        end
    end

    // seen count must start at zero; payload cleared with it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule
